@@ design/segpoly_pkg.sv @@
// ----------------------------------------------------------------------------
// segpoly_pkg
// Types and constants shared by the segment against polygon intersection unit.
// ----------------------------------------------------------------------------
package segpoly_pkg;

  localparam int COORD_BITS       = 16;
  localparam int DEF_MAX_VERTICES = 16;
  localparam int HIT_SLOTS        = 15;
  localparam int K_BITS           = 17;
  localparam int FRAC_STEPS       = 16;
  // abs of a determinant or numerator built from two 17x17 products
  localparam int MAG_BITS         = 2 * (COORD_BITS + 1);
  localparam int PT_BITS          = 24;
  localparam int IDX_BITS         = 4;
  localparam int TOL_BITS         = 16;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                       opcode;
    logic                          new_polygon;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  seg_end_x;
    logic signed [COORD_BITS-1:0]  seg_end_y;
  } in_item_t;

  typedef struct packed {
    logic                        none_found;
    logic [K_BITS-1:0]           hit_k;
    logic signed [PT_BITS-1:0]   hit_x;
    logic signed [PT_BITS-1:0]   hit_y;
    logic [IDX_BITS-1:0]         edge_index;
    logic [IDX_BITS-1:0]         hit_count;
    logic                        overflow;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic [K_BITS-1:0]    q;
    logic [MAG_BITS-1:0]  r;
  } div_res_t;

endpackage

@@ design/segpoly_div.sv @@
// ----------------------------------------------------------------------------
// segpoly_div
// Restoring divider: floor(num * 2^16 / den) and remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module segpoly_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [segpoly_pkg::MAG_BITS-1:0]    num,
  input  logic [segpoly_pkg::MAG_BITS-1:0]    den,
  output logic                                done,
  output segpoly_pkg::div_res_t               res
);

  localparam int W  = segpoly_pkg::MAG_BITS;
  localparam int KB = segpoly_pkg::K_BITS;
  localparam int CB = $clog2(segpoly_pkg::FRAC_STEPS + 1);

  logic [W:0]    r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [KB-1:0] q_r, q_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    r_sh;

  always_comb begin
    r_nxt    = r_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r_sh     = {r_r[W-1:0], 1'b0};
    if (start) begin
      // num never exceeds den, so the integer part is 0 or 1
      d_nxt    = den;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      if (num >= den) begin
        q_nxt = KB'(1);
        r_nxt = {1'b0, num - den};
      end else begin
        q_nxt = '0;
        r_nxt = {1'b0, num};
      end
    end else if (busy_r) begin
      if (r_sh >= {1'b0, d_r}) begin
        r_nxt = r_sh - {1'b0, d_r};
        q_nxt = {q_r[KB-2:0], 1'b1};
      end else begin
        r_nxt = r_sh;
        q_nxt = {q_r[KB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CB'(1);
      if (cnt_r == CB'(segpoly_pkg::FRAC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    r_r <= r_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
  end

  assign done  = done_r;
  assign res.q = q_r;
  assign res.r = r_r[W-1:0];

endmodule

@@ design/segment_polygon_intersections_top.sv @@
// ----------------------------------------------------------------------------
// segment_polygon_intersections_top
// Stores one polygon and intersects query segments with its edges, giving
// hits in ascending position along the segment.
// ----------------------------------------------------------------------------
//  port group   dir  handshake          payload
//  in_*         in   in_valid/in_stall  in_data   (segpoly_pkg::in_item_t)
//  out_*        out  out_valid/out_stall out_data (segpoly_pkg::out_item_t)
//  cfg_*        in   cfg_valid/cfg_ready cfg_data (edge tolerance, Q0.16)
//
//  A load leaves the unit idle for the next item. A query walks the edges:
//  each goes through the shared multiplier and the range test, one that
//  passes through the 16-step divider and the tolerance test, and a kept
//  hit is sorted in with up to 14 shifts. Then one result item goes out per
//  cycle unless out_stall holds it. in_stall is high for the whole query.
//  Reset is synchronous; the vertex store needs no clearing.
//  out_stall holds the output register; a stall only delays the query.
// ----------------------------------------------------------------------------
module segment_polygon_intersections_top #(
  parameter int MAX_VERTICES = segpoly_pkg::DEF_MAX_VERTICES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  segpoly_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output segpoly_pkg::out_item_t             out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [segpoly_pkg::TOL_BITS-1:0]   cfg_data
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int CB  = segpoly_pkg::COORD_BITS;
  localparam int DB  = CB + 1;
  localparam int MB  = 2 * (DB + 1);
  localparam int AB  = MB - 1;
  localparam int W   = segpoly_pkg::MAG_BITS;
  localparam int KB  = segpoly_pkg::K_BITS;
  localparam int PB  = segpoly_pkg::PT_BITS;
  localparam int IB  = segpoly_pkg::IDX_BITS;
  localparam int HS  = segpoly_pkg::HIT_SLOTS;
  localparam int TOL_W = segpoly_pkg::TOL_BITS;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_DIFF = 11'b00000000100,
    S_MUL  = 11'b00000001000,
    S_CHK  = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_TOL  = 11'b00001000000,
    S_PMUL = 11'b00010000000,
    S_INS  = 11'b00100000000,
    S_NEXT = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CB-1:0] vx_mem [MAX_VERTICES];
  logic signed [CB-1:0] vy_mem [MAX_VERTICES];
  logic [CW-1:0]        vcount_r, vcount_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [TOL_W-1:0]     tol_r;

  logic signed [CB-1:0] ax_r, ay_r;
  logic signed [DB-1:0] alx_r, aly_r;
  logic signed [CB-1:0] cx_r, cy_r, nx_r, ny_r;
  logic signed [DB-1:0] btx_r, bty_r, da_r, db_r;
  logic signed [MB-1:0] prod_r;
  logic signed [AB-1:0] den_r, kn_r, tn_r;
  logic [W-1:0]         dabs_r;
  logic [KB-1:0]        kq_r;
  logic signed [PB-1:0] px_r;
  logic [2:0]           step_r, step_nxt;
  logic [AW-1:0]        e_r, e_nxt;
  logic [IB-1:0]        n_r, n_nxt;
  logic [IB-1:0]        j_r, j_nxt;

  logic [KB-1:0]        hk_buf [HS];
  logic signed [PB-1:0] hx_buf [HS];
  logic signed [PB-1:0] hy_buf [HS];
  logic [IB-1:0]        he_buf [HS];

  logic                 out_valid_r, out_valid_nxt;
  segpoly_pkg::out_item_t out_data_r, out_data_nxt;

  logic signed [DB:0]   mul_a, mul_b;
  logic signed [MB-1:0] mul_p;
  logic                 div_start;
  logic                 div_done;
  segpoly_pkg::div_res_t div_res;
  logic signed [AB-1:0] den_n, kn_n, tn_n;
  logic                 chk_ok;
  logic [KB-1:0]        upper;
  logic                 tol_ok;
  logic [KB-1:0]        kq_c;
  logic [IB-1:0]        rd_idx;
  logic                 in_acc;
  logic                 out_take;
  logic signed [PB-1:0] pt_c;
  logic [2:0]           acc_sel;

  // round(p / 256) with ties away from zero, then start*256 minus that
  function automatic logic signed [PB-1:0] point_of(
    input logic signed [CB-1:0] s, input logic signed [MB-1:0] p);
    logic [MB-1:0]        m;
    logic [MB-1:0]        q;
    logic signed [MB-1:0] off;
    logic signed [MB-1:0] base;
    m    = p[MB-1] ? MB'(-p) : MB'(p);
    q    = (m + MB'(128)) >> 8;
    off  = p[MB-1] ? -$signed(q) : $signed(q);
    base = $signed({{(MB-CB-8){s[CB-1]}}, s, 8'b0});
    return PB'(base - off);
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_take  = out_valid_r && !out_stall;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_PMUL) begin
      mul_a = (step_r == 3'd0) ? (DB+1)'(alx_r) : (DB+1)'(aly_r);
      mul_b = $signed({1'b0, kq_r});
    end else begin
      case (step_r)
        3'd0: begin mul_a = (DB+1)'(btx_r); mul_b = (DB+1)'(aly_r); end
        3'd1: begin mul_a = (DB+1)'(alx_r); mul_b = (DB+1)'(bty_r); end
        3'd2: begin mul_a = (DB+1)'(btx_r); mul_b = (DB+1)'(db_r);  end
        3'd3: begin mul_a = (DB+1)'(bty_r); mul_b = (DB+1)'(da_r);  end
        3'd4: begin mul_a = (DB+1)'(aly_r); mul_b = (DB+1)'(da_r);  end
        3'd5: begin mul_a = (DB+1)'(alx_r); mul_b = (DB+1)'(db_r);  end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_p   = mul_a * mul_b;
  assign acc_sel = step_r - 3'd1;

  // sign normalisation and range test
  always_comb begin
    if (den_r[AB-1]) begin
      den_n = -den_r;
      kn_n  = -kn_r;
      tn_n  = -tn_r;
    end else begin
      den_n = den_r;
      kn_n  = kn_r;
      tn_n  = tn_r;
    end
    chk_ok = (den_r != '0) && !kn_n[AB-1] && !tn_n[AB-1] &&
             (kn_n <= den_n) && (tn_n <= den_n);
  end

  assign div_start = (state_r == S_CHK) && chk_ok;

  segpoly_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (W'(kn_n)),
    .den   (W'(den_n)),
    .done  (div_done),
    .res   (div_res)
  );

  assign upper  = KB'(17'd65536) - KB'(tol_r);
  assign tol_ok = (div_res.q >= KB'(tol_r)) && (div_res.q <= upper) &&
                  !((div_res.q == upper) && (div_res.r != '0)) &&
                  (n_r < IB'(HS));
  assign kq_c   = div_res.q + KB'(({div_res.r, 1'b0} >= {1'b0, dabs_r}) ? 1 : 0);
  assign rd_idx = (state_r == S_EMIT) ? j_r : j_r - IB'(1);
  assign pt_c   = point_of((step_r == 3'd1) ? ax_r : ay_r, prod_r);

  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    ovf_nxt       = ovf_r;
    step_nxt      = step_r;
    e_nxt         = e_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == segpoly_pkg::OP_LOAD) begin
            if (in_data.new_polygon) begin
              vcount_nxt = '0;
              ovf_nxt    = 1'b0;
              if (MAX_VERTICES > 0) begin
                vcount_nxt = CW'(1);
              end
            end else if (vcount_r < CW'(MAX_VERTICES)) begin
              vcount_nxt = vcount_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            n_nxt = '0;
            e_nxt = '0;
            j_nxt = '0;
            state_nxt = (vcount_r >= CW'(2)) ? S_RD : S_EMIT;
          end
        end
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: begin
        step_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd6) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK:  state_nxt = chk_ok ? S_DIV : S_NEXT;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_TOL;
        end
      end
      S_TOL: begin
        step_nxt  = '0;
        state_nxt = tol_ok ? S_PMUL : S_NEXT;
      end
      S_PMUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd2) begin
          j_nxt     = n_r;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if ((j_r != '0) && (hk_buf[rd_idx] > kq_r)) begin
          j_nxt = j_r - IB'(1);
        end else begin
          n_nxt     = n_r + IB'(1);
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if ((CW+1)'(e_r) + (CW+1)'(2) < (CW+1)'(vcount_r)) begin
          e_nxt     = e_r + AW'(1);
          state_nxt = S_RD;
        end else begin
          j_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.overflow = ovf_r;
          if (n_r < IB'(2)) begin
            out_data_nxt.none_found = 1'b1;
            out_data_nxt.last       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            out_data_nxt.hit_k      = hk_buf[rd_idx];
            out_data_nxt.hit_x      = hx_buf[rd_idx];
            out_data_nxt.hit_y      = hy_buf[rd_idx];
            out_data_nxt.edge_index = he_buf[rd_idx];
            out_data_nxt.hit_count  = n_r;
            out_data_nxt.last       = (j_r == n_r - IB'(1));
            j_nxt = j_r + IB'(1);
            if (j_r == n_r - IB'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      ovf_r       <= 1'b0;
      tol_r       <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
    end
    step_r     <= step_nxt;
    e_r        <= e_nxt;
    j_r        <= j_nxt;
    out_data_r <= out_data_nxt;
  end

  // vertex store, query operands and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.opcode == segpoly_pkg::OP_LOAD)) begin
      if (in_data.new_polygon) begin
        vx_mem[0] <= in_data.point_x;
        vy_mem[0] <= in_data.point_y;
      end else if (vcount_r < CW'(MAX_VERTICES)) begin
        vx_mem[vcount_r[AW-1:0]] <= in_data.point_x;
        vy_mem[vcount_r[AW-1:0]] <= in_data.point_y;
      end
    end
    if (in_acc && (in_data.opcode == segpoly_pkg::OP_QUERY)) begin
      ax_r  <= in_data.point_x;
      ay_r  <= in_data.point_y;
      alx_r <= DB'(in_data.point_x) - DB'(in_data.seg_end_x);
      aly_r <= DB'(in_data.point_y) - DB'(in_data.seg_end_y);
    end
    if (state_r == S_RD) begin
      cx_r <= vx_mem[e_r];
      cy_r <= vy_mem[e_r];
      nx_r <= vx_mem[AW'(e_r + AW'(1))];
      ny_r <= vy_mem[AW'(e_r + AW'(1))];
    end
    if (state_r == S_DIFF) begin
      btx_r <= DB'(nx_r) - DB'(cx_r);
      bty_r <= DB'(ny_r) - DB'(cy_r);
      da_r  <= DB'(ax_r) - DB'(cx_r);
      db_r  <= DB'(ay_r) - DB'(cy_r);
    end
    if ((state_r == S_MUL) || (state_r == S_PMUL)) begin
      prod_r <= mul_p;
    end
    if ((state_r == S_MUL) && (step_r != 3'd0)) begin
      case (acc_sel)
        3'd0: den_r <= AB'(prod_r);
        3'd1: den_r <= den_r - AB'(prod_r);
        3'd2: kn_r  <= AB'(prod_r);
        3'd3: kn_r  <= kn_r - AB'(prod_r);
        3'd4: tn_r  <= AB'(prod_r);
        3'd5: tn_r  <= tn_r - AB'(prod_r);
        default: den_r <= den_r;
      endcase
    end
    if (div_start) begin
      dabs_r <= W'(den_n);
    end
    if ((state_r == S_TOL) && tol_ok) begin
      kq_r <= kq_c;
    end
    if ((state_r == S_PMUL) && (step_r == 3'd1)) begin
      px_r <= pt_c;
    end
    if (state_r == S_INS) begin
      if ((j_r != '0) && (hk_buf[rd_idx] > kq_r)) begin
        hk_buf[j_r] <= hk_buf[rd_idx];
        hx_buf[j_r] <= hx_buf[rd_idx];
        hy_buf[j_r] <= hy_buf[rd_idx];
        he_buf[j_r] <= he_buf[rd_idx];
      end else begin
        hk_buf[j_r] <= kq_r;
        hx_buf[j_r] <= px_r;
        hy_buf[j_r] <= point_of(ay_r, prod_r);
        he_buf[j_r] <= IB'(e_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= IB'(HS)) else $error("hit count beyond slot count");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV)) else $error("divider finished outside wait");

  a_ins_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (j_r <= n_r)) else $error("insert slot beyond fill");

  a_hit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.none_found) |-> (out_data_r.hit_count >= IB'(2)))
    else $error("hit item with fewer than two hits");

endmodule

@@ test/segment_polygon_intersections_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_polygon_intersections_top_tb
// Loads polygons, queries segments against them and checks every hit item
// against a predictor kept in the bench, across several edge tolerances.
// ----------------------------------------------------------------------------

class hit_scoreboard;
  logic signed [segpoly_pkg::COORD_BITS-1:0] vx[segpoly_pkg::DEF_MAX_VERTICES];
  logic signed [segpoly_pkg::COORD_BITS-1:0] vy[segpoly_pkg::DEF_MAX_VERTICES];
  int unsigned nverts;
  bit          ovf;
  logic [segpoly_pkg::TOL_BITS-1:0] tol;
  segpoly_pkg::out_item_t pending[$];
  int          errors;

  function new();
    nverts = 0;
    ovf = 0;
    tol = '0;
    errors = 0;
  endfunction

  // round(d * kq / 256), ties away from zero
  function longint scale_off(longint d, longint kq);
    longint p;
    longint m;
    p = d * kq;
    m = (p < 0) ? -p : p;
    m = (m + 128) >>> 8;
    return (p < 0) ? -m : m;
  endfunction

  function void note_input(segpoly_pkg::in_item_t it);
    longint ax, ay, alx, aly, cx, cy, btx, bty, pa, pb, den, kn, tn;
    longint q, r, upper, kq;
    longint ks[$];
    longint hx[$];
    longint hy[$];
    int     ed[$];
    int     j, n;
    segpoly_pkg::out_item_t o;
    ax = it.point_x;
    ay = it.point_y;
    if (it.opcode == segpoly_pkg::OP_LOAD) begin
      if (it.new_polygon) begin
        nverts = 0;
        ovf = 0;
      end
      if (nverts < segpoly_pkg::DEF_MAX_VERTICES) begin
        vx[nverts] = it.point_x;
        vy[nverts] = it.point_y;
        nverts++;
      end else begin
        ovf = 1;
      end
      return;
    end
    alx = ax - longint'(it.seg_end_x);
    aly = ay - longint'(it.seg_end_y);
    for (int e = 0; e + 1 < nverts; e++) begin
      cx = vx[e];
      cy = vy[e];
      btx = longint'(vx[e+1]) - cx;
      bty = longint'(vy[e+1]) - cy;
      pa = ax - cx;
      pb = ay - cy;
      den = btx * aly - alx * bty;
      kn = btx * pb - bty * pa;
      tn = aly * pa - alx * pb;
      if (den == 0) continue;
      if (den < 0) begin
        den = -den;
        kn = -kn;
        tn = -tn;
      end
      if (kn < 0 || kn > den || tn < 0 || tn > den) continue;
      q = (kn * 65536) / den;
      r = (kn * 65536) % den;
      if (q < longint'(tol)) continue;
      upper = 65536 - longint'(tol);
      if (q > upper || (q == upper && r != 0)) continue;
      if (ks.size() >= segpoly_pkg::HIT_SLOTS) continue;
      kq = q + ((2 * r >= den) ? 1 : 0);
      j = ks.size();
      while (j > 0 && ks[j-1] > kq) j--;
      ks.insert(j, kq);
      hx.insert(j, ax * 256 - scale_off(alx, kq));
      hy.insert(j, ay * 256 - scale_off(aly, kq));
      ed.insert(j, e);
    end
    n = ks.size();
    if (n < 2) begin
      o = '0;
      o.none_found = 1'b1;
      o.overflow = ovf;
      o.last = 1'b1;
      pending.insert(pending.size(), o);
      return;
    end
    for (int i = 0; i < n; i++) begin
      o.none_found = 1'b0;
      o.hit_k = ks[i][segpoly_pkg::K_BITS-1:0];
      o.hit_x = hx[i][segpoly_pkg::PT_BITS-1:0];
      o.hit_y = hy[i][segpoly_pkg::PT_BITS-1:0];
      o.edge_index = ed[i][segpoly_pkg::IDX_BITS-1:0];
      o.hit_count = n[segpoly_pkg::IDX_BITS-1:0];
      o.overflow = ovf;
      o.last = (i + 1 == n);
      pending.insert(pending.size(), o);
    end
  endfunction

  function void check_result(segpoly_pkg::out_item_t got);
    segpoly_pkg::out_item_t x;
    if (pending.size() == 0) begin
      $error("unexpected result item %p", got);
      errors++;
      return;
    end
    x = pending[0];
    pending.delete(0);
    if (got.none_found !== x.none_found) begin
      $error("none_found exp %0d got %0d", x.none_found, got.none_found); errors++;
    end
    if (got.hit_k !== x.hit_k) begin
      $error("hit_k exp %0d got %0d", x.hit_k, got.hit_k); errors++;
    end
    if (got.hit_x !== x.hit_x) begin
      $error("hit_x exp %0d got %0d", x.hit_x, got.hit_x); errors++;
    end
    if (got.hit_y !== x.hit_y) begin
      $error("hit_y exp %0d got %0d", x.hit_y, got.hit_y); errors++;
    end
    if (got.edge_index !== x.edge_index) begin
      $error("edge_index exp %0d got %0d", x.edge_index, got.edge_index); errors++;
    end
    if (got.hit_count !== x.hit_count) begin
      $error("hit_count exp %0d got %0d", x.hit_count, got.hit_count); errors++;
    end
    if (got.overflow !== x.overflow) begin
      $error("overflow exp %0d got %0d", x.overflow, got.overflow); errors++;
    end
    if (got.last !== x.last) begin
      $error("last exp %0d got %0d", x.last, got.last); errors++;
    end
  endfunction
endclass

module segment_polygon_intersections_top_tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int CB = segpoly_pkg::COORD_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  segpoly_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  segpoly_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [segpoly_pkg::TOL_BITS-1:0] cfg_data = '0;

  hit_scoreboard sb = new();
  bit quiet_phase = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  segment_polygon_intersections_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // sample outputs at the edge, against values from before it
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[segment_polygon_intersections_top] ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        k = int'($urandom_range(1, 9));
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // valid stays high after an accept; whoever idles next drops it
  task automatic send_item(segpoly_pkg::in_item_t it);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic write_tolerance(logic [segpoly_pkg::TOL_BITS-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.tol = v;
  endtask

  function automatic segpoly_pkg::in_item_t vertex(bit fresh, int x, int y);
    segpoly_pkg::in_item_t it;
    it = '0;
    it.opcode = segpoly_pkg::OP_LOAD;
    it.new_polygon = fresh;
    it.point_x = CB'(x);
    it.point_y = CB'(y);
    it.seg_end_x = CB'($urandom);
    it.seg_end_y = CB'($urandom);
    return it;
  endfunction

  function automatic segpoly_pkg::in_item_t segment(int ax, int ay, int bx, int by);
    segpoly_pkg::in_item_t it;
    it.opcode = segpoly_pkg::OP_QUERY;
    it.new_polygon = 1'($urandom);
    it.point_x = CB'(ax);
    it.point_y = CB'(ay);
    it.seg_end_x = CB'(bx);
    it.seg_end_y = CB'(by);
    return it;
  endfunction

  function automatic int rnd_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_polygon(int span);
    int nv, x0, y0;
    nv = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 19))
                                     : int'($urandom_range(3, 8));
    x0 = rnd_coord(span);
    y0 = rnd_coord(span);
    send_item(vertex(1, x0, y0));
    for (int i = 1; i < nv - 1; i++) send_item(vertex(0, rnd_coord(span), rnd_coord(span)));
    if (nv > 1) send_item(vertex(0, x0, y0));
  endtask

  task automatic random_phase(int count);
    int span;
    int sent;
    sent = 0;
    while (sent < count) begin
      span = ($urandom_range(0, 3) == 0) ? 32767 : int'($urandom_range(4, 300));
      random_polygon(span);
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(segment($urandom, $urandom, $urandom, $urandom));
        else
          send_item(segment(rnd_coord(span + span / 2), rnd_coord(span + span / 2),
                            rnd_coord(span + span / 2), rnd_coord(span + span / 2)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // query with no polygon, then a square crossed straight through
    send_item(segment(0, 0, 10, 10));
    send_item(vertex(1, -100, -100));
    send_item(segment(-200, 0, 200, 0));
    send_item(vertex(0, 100, -100));
    send_item(vertex(0, 100, 100));
    send_item(vertex(0, -100, 100));
    send_item(vertex(0, -100, -100));
    send_item(segment(-200, 0, 200, 0));
    send_item(segment(200, 3, -200, 7));
    send_item(segment(-100, -100, 100, 100));  // through corners: equal k
    send_item(segment(5, 5, 5, 5));            // zero-length segment
    send_item(segment(-200, 100, 200, 100));   // along an edge
    // extreme coordinates, including a zero-length edge
    send_item(vertex(1, -32768, -32768));
    send_item(vertex(0, 32767, -32768));
    send_item(vertex(0, 32767, -32768));
    send_item(vertex(0, 32767, 32767));
    send_item(vertex(0, -32768, 32767));
    send_item(vertex(0, -32768, -32768));
    send_item(segment(-32768, 0, 32767, 1));
    send_item(segment(32767, 32767, -32768, -32768));
    // overfill the store
    send_item(vertex(1, 0, -50));
    for (int i = 1; i < 18; i++) send_item(vertex(0, (i % 2) ? 50 : -50, i * 10 - 50));
    send_item(segment(0, -60, 0, 150));
    write_tolerance(16'd8192);
    send_item(segment(-200, 0, 200, 0));
    random_phase(55);
    write_tolerance(16'd32768);
    send_item(vertex(1, -100, -100));
    send_item(vertex(0, 100, -100));
    send_item(vertex(0, 100, 100));
    send_item(vertex(0, -100, 100));
    send_item(vertex(0, -100, -100));
    send_item(segment(-100, 0, 100, 0));
    write_tolerance(16'hFFFF);
    random_phase(15);
    write_tolerance(16'd1000);
    random_phase(25);
    write_tolerance(16'd0);
    random_phase(35);
    quiet_phase = 1;
    random_phase(20);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0)
      $display("[segment_polygon_intersections_top] OK");
    else
      $display("[segment_polygon_intersections_top] ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
design/segpoly_pkg.sv
design/segpoly_div.sv
design/segment_polygon_intersections_top.sv
test/segment_polygon_intersections_top_tb.sv
